[hdl/sphere_frustum_classifier_macros.svh]
// Assertion macros used by the sphere classifier top level.
`ifndef SPHERE_FRUSTUM_CLASSIFIER_MACROS_SVH
`define SPHERE_FRUSTUM_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define SFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sphere classifier check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sphere classifier check failed");
`else
`define SFC_ASSERT_NOW(label, ante, cons)
`define SFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/sfc_pkg.sv]
// Shared types and constants of the sphere classifier.
`default_nettype none
package sfc_pkg;

    localparam int FIELD_BITS = 32;
    localparam int KIND_BITS  = 2;
    localparam int ENTRY_BITS = 3;
    localparam int CLASS_BITS = 3;
    localparam int CULL_BITS  = 2;
    localparam int FRAC_BITS  = 16;
    localparam int LANES      = 3;

    // Request kinds.
    localparam logic [KIND_BITS-1:0] KIND_PLANE    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_CORNER   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLASSIFY = 2'd2;

    localparam logic [ENTRY_BITS-1:0] NUM_PLANES  = 3'd6;
    localparam logic [ENTRY_BITS-1:0] PLANE_NEAR  = 3'd0;
    localparam logic [ENTRY_BITS-1:0] PLANE_FAR   = 3'd1;
    localparam logic [ENTRY_BITS-1:0] PLANE_LAST  = 3'd5;
    localparam logic [ENTRY_BITS-1:0] CORNER_LAST = 3'd7;

    // Position classes.
    localparam logic [CLASS_BITS-1:0] CLS_OUTSIDE = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLS_FILL    = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLS_INSIDE  = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLS_FAR     = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLS_BEHIND  = 3'd4;

    // Cull modes.
    localparam logic [CULL_BITS-1:0] CULL_NONE  = 2'd0;
    localparam logic [CULL_BITS-1:0] CULL_FRONT = 2'd1;
    localparam logic [CULL_BITS-1:0] CULL_BACK  = 2'd2;

    typedef enum logic [1:0] {
        STEP_RADIUS = 2'd0,
        STEP_CORNER = 2'd1,
        STEP_PLANE  = 2'd2
    } step_kind_t;

    typedef struct packed {
        logic                  valid;
        step_kind_t            kind;
        logic [ENTRY_BITS-1:0] idx;
        logic                  last;
    } step_tag_t;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        step_kind_t            kind;
        logic [ENTRY_BITS-1:0] idx;
        logic                  out_range;
        logic                  outside;
        logic                  below;
        logic                  in_band;
    } step_flags_t;

endpackage
`default_nettype wire

[hdl/sfc_if.sv]
// Request and response channel interfaces of the sphere classifier.
`default_nettype none
interface sfc_req_if
    import sfc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [KIND_BITS-1:0]         kind;
    logic [ENTRY_BITS-1:0]        index;
    logic signed [FIELD_BITS-1:0] x;
    logic signed [FIELD_BITS-1:0] y;
    logic signed [FIELD_BITS-1:0] z;
    logic signed [FIELD_BITS-1:0] w;

    modport source (output valid, kind, index, x, y, z, w, input ready);
    modport sink (input valid, kind, index, x, y, z, w, output ready);
endinterface

interface sfc_rsp_if
    import sfc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CLASS_BITS-1:0] position_class;
    logic                  depth_test_less;
    logic [CULL_BITS-1:0]  cull_mode;

    modport source (output valid, position_class, depth_test_less, cull_mode, input ready);
    modport sink (input valid, position_class, depth_test_less, cull_mode, output ready);
endinterface
`default_nettype wire

[hdl/sfc_store.sv]
// Plane and corner memories with registered read data.
`default_nettype none
module sfc_store
    import sfc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_plane_en,
    input  logic                          wr_corner_en,
    input  logic [ENTRY_BITS-1:0]         wr_idx,
    input  logic signed [COORD_BITS-1:0]  wr_x,
    input  logic signed [COORD_BITS-1:0]  wr_y,
    input  logic signed [COORD_BITS-1:0]  wr_z,
    input  logic signed [COORD_BITS-1:0]  wr_w,
    input  step_tag_t                     rd_tag,
    output step_tag_t                     rd_tag_out,
    output logic [4*COORD_BITS-1:0]       plane_row,
    output logic [3*COORD_BITS-1:0]       corner_row
);

    localparam int PLANE_DEPTH  = 6;
    localparam int CORNER_DEPTH = 8;

    logic [4*COORD_BITS-1:0] plane_mem [PLANE_DEPTH];
    logic [3*COORD_BITS-1:0] corner_mem [CORNER_DEPTH];
    logic [4*COORD_BITS-1:0] plane_rd_reg;
    logic [3*COORD_BITS-1:0] corner_rd_reg;
    step_tag_t               tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_plane_en)
        begin
            plane_mem[wr_idx] <= {wr_w, wr_z, wr_y, wr_x};
        end
        if (wr_corner_en)
        begin
            corner_mem[wr_idx] <= {wr_z, wr_y, wr_x};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_tag.valid && (rd_tag.kind == STEP_PLANE))
        begin
            plane_rd_reg <= plane_mem[rd_tag.idx];
        end
        if (rd_tag.valid && (rd_tag.kind == STEP_CORNER))
        begin
            corner_rd_reg <= corner_mem[rd_tag.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= rd_tag;
        end
    end

    assign rd_tag_out = tag_reg;
    assign plane_row  = plane_rd_reg;
    assign corner_row = corner_rd_reg;

endmodule
`default_nettype wire

[hdl/sfc_dot.sv]
// Three-lane multiply-accumulate datapath that turns one store row into test flags.
`default_nettype none
module sfc_dot
    import sfc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  step_tag_t                    tag_in,
    input  logic [4*COORD_BITS-1:0]      plane_row,
    input  logic [3*COORD_BITS-1:0]      corner_row,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    input  logic signed [COORD_BITS-1:0] rad,
    output step_flags_t                  flags
);

    localparam int OP_W   = COORD_BITS + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [COORD_BITS-1:0] pos_c    [LANES];
    logic signed [COORD_BITS-1:0] corner_c [LANES];
    logic signed [COORD_BITS-1:0] plane_c  [LANES];
    logic signed [COORD_BITS-1:0] plane_d;

    logic signed [OP_W-1:0]       opa_next [LANES];
    logic signed [OP_W-1:0]       opb_next [LANES];
    logic signed [COORD_BITS-1:0] dco_next;
    logic signed [OP_W-1:0]       opa_reg  [LANES];
    logic signed [OP_W-1:0]       opb_reg  [LANES];
    logic signed [COORD_BITS-1:0] dco_reg;
    step_tag_t                    tag_s2_reg;

    logic signed [PROD_W-1:0]     prod_reg [LANES];
    logic signed [COORD_BITS-1:0] d_s3_reg;
    step_tag_t                    tag_s3_reg;

    logic signed [SUM_W-1:0]      sum_next;
    logic signed [SUM_W-1:0]      sum_reg;
    step_tag_t                    tag_s4_reg;

    logic signed [SUM_W-1:0]      r2_reg;
    logic signed [SUM_W-1:0]      rq;
    logic signed [SUM_W-1:0]      neg_rq;
    step_flags_t                  flags_next;
    step_flags_t                  flags_reg;

    assign pos_c[0] = px;
    assign pos_c[1] = py;
    assign pos_c[2] = pz;
    assign plane_d  = $signed(plane_row[3*COORD_BITS +: COORD_BITS]);

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        assign corner_c[g] = $signed(corner_row[g*COORD_BITS +: COORD_BITS]);
        assign plane_c[g]  = $signed(plane_row[g*COORD_BITS +: COORD_BITS]);
    end

    // Operand selection: a corner squares its offset, a plane multiplies
    // its normal by the centre, the radius step squares the range.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            opa_next[i] = '0;
            opb_next[i] = '0;
        end
        dco_next = '0;
        case (tag_in.kind)
            STEP_RADIUS:
            begin
                opa_next[0] = OP_W'(rad);
                opb_next[0] = OP_W'(rad);
            end
            STEP_CORNER:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    opa_next[i] = OP_W'(corner_c[i]) - OP_W'(pos_c[i]);
                    opb_next[i] = OP_W'(corner_c[i]) - OP_W'(pos_c[i]);
                end
            end
            STEP_PLANE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    opa_next[i] = OP_W'(plane_c[i]);
                    opb_next[i] = OP_W'(pos_c[i]);
                end
                dco_next = plane_d;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            opa_reg[i]  <= opa_next[i];
            opb_reg[i]  <= opb_next[i];
            prod_reg[i] <= PROD_W'(opa_reg[i]) * PROD_W'(opb_reg[i]);
        end
        dco_reg  <= dco_next;
        d_s3_reg <= dco_reg;
        sum_reg  <= sum_next;
    end

    // The plane offset d is Q16.16 and the products are Q32.32.
    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                    + (SUM_W'(d_s3_reg) <<< FRAC_BITS);

    assign rq     = SUM_W'(rad) <<< FRAC_BITS;
    assign neg_rq = -rq;

    always_comb
    begin
        flags_next.valid     = tag_s4_reg.valid;
        flags_next.last      = tag_s4_reg.last;
        flags_next.kind      = tag_s4_reg.kind;
        flags_next.idx       = tag_s4_reg.idx;
        flags_next.out_range = (sum_reg > r2_reg);
        flags_next.outside   = (sum_reg <= neg_rq);
        flags_next.below     = sum_reg[SUM_W-1];
        flags_next.in_band   = (sum_reg < rq) && (sum_reg > neg_rq);
    end

    always_ff @(posedge clk)
    begin
        if (tag_s4_reg.valid && (tag_s4_reg.kind == STEP_RADIUS))
        begin
            r2_reg <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_s4_reg <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            tag_s2_reg <= tag_in;
            tag_s3_reg <= tag_s2_reg;
            tag_s4_reg <= tag_s3_reg;
            flags_reg  <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule
`default_nettype wire

[hdl/sphere_frustum_classifier.sv]
// Sphere-versus-frustum classifier: sequencer, flag collection and response register.
//
// Requests arrive on req (valid/ready). A plane load (kind 0) or corner load
// (kind 1) is written into the plane or corner memory at the edge it is
// accepted and produces no response; plane loads at index six or seven and
// requests of kind three are taken and dropped. A classify request (kind 2)
// starts a walk of fifteen steps through the memories: the squared range, the
// eight corners, then the six planes, one memory row per cycle, each row
// feeding a three-lane multiply-accumulate pipeline of four stages.
// The response appears on rsp once the walk has passed through the memory
// read register and that pipeline. req is ready again from the cycle in which
// the response appears, so a classify holds off all other requests until it
// completes, and loads go at one per cycle while no classify is in progress.
// If rsp is stalled when a result is due, the block holds it and keeps req
// low until the response register is free; a waiting response does not stop
// loads or the next classify from being accepted.
// Reset clears the control state and the response valid; memory contents are
// undefined until loaded, and all planes and corners must be loaded before
// the first classify.
`default_nettype none
`include "sphere_frustum_classifier_macros.svh"
module sphere_frustum_classifier
    import sfc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    sfc_req_if.sink   req,
    sfc_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    step_kind_t              step_kind_reg, step_kind_next;
    logic [ENTRY_BITS-1:0]   step_idx_reg, step_idx_next;

    logic signed [COORD_BITS-1:0] x_c, y_c, z_c, w_c;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg, rad_reg;

    logic accept;
    logic accept_classify;
    logic wr_plane_en;
    logic wr_corner_en;
    logic rsp_free;

    step_tag_t   rd_tag;
    step_tag_t   mem_tag;
    step_flags_t flags;
    logic [4*COORD_BITS-1:0] plane_row;
    logic [3*COORD_BITS-1:0] corner_row;

    logic all_in_reg, outside_reg, far_reg, behind_reg, crossed_reg;

    logic                  rsp_valid_reg;
    logic [CLASS_BITS-1:0] class_reg, class_next;
    logic                  depth_less_reg;
    logic [CULL_BITS-1:0]  cull_reg;

    assign x_c = $signed(req.x[COORD_BITS-1:0]);
    assign y_c = $signed(req.y[COORD_BITS-1:0]);
    assign z_c = $signed(req.z[COORD_BITS-1:0]);
    assign w_c = $signed(req.w[COORD_BITS-1:0]);

    assign req.ready       = (state_reg == ST_IDLE);
    assign accept          = req.valid && req.ready;
    assign accept_classify = accept && (req.kind == KIND_CLASSIFY);
    assign wr_plane_en     = accept && (req.kind == KIND_PLANE) && (req.index < NUM_PLANES);
    assign wr_corner_en    = accept && (req.kind == KIND_CORNER);
    assign rsp_free        = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rd_tag.valid = (state_reg == ST_RUN);
        rd_tag.kind  = step_kind_reg;
        rd_tag.idx   = step_idx_reg;
        rd_tag.last  = (step_kind_reg == STEP_PLANE) && (step_idx_reg == PLANE_LAST);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_kind_next = step_kind_reg;
        step_idx_next  = step_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_classify)
                begin
                    state_next     = ST_RUN;
                    step_kind_next = STEP_RADIUS;
                    step_idx_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_kind_reg == STEP_RADIUS)
                begin
                    step_kind_next = STEP_CORNER;
                    step_idx_next  = '0;
                end
                else if (step_kind_reg == STEP_CORNER)
                begin
                    if (step_idx_reg == CORNER_LAST)
                    begin
                        step_kind_next = STEP_PLANE;
                        step_idx_next  = '0;
                    end
                    else
                    begin
                        step_idx_next = step_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    step_idx_next = step_idx_reg + 1'b1;
                    if (step_idx_reg == PLANE_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (flags.valid && flags.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_kind_reg <= STEP_RADIUS;
            step_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_kind_reg <= step_kind_next;
            step_idx_reg  <= step_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_classify)
        begin
            px_reg  <= x_c;
            py_reg  <= y_c;
            pz_reg  <= z_c;
            rad_reg <= w_c;
        end
    end

    sfc_store #(
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_plane_en  (wr_plane_en),
        .wr_corner_en (wr_corner_en),
        .wr_idx       (req.index),
        .wr_x         (x_c),
        .wr_y         (y_c),
        .wr_z         (z_c),
        .wr_w         (w_c),
        .rd_tag       (rd_tag),
        .rd_tag_out   (mem_tag),
        .plane_row    (plane_row),
        .corner_row   (corner_row)
    );

    sfc_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_in     (mem_tag),
        .plane_row  (plane_row),
        .corner_row (corner_row),
        .px         (px_reg),
        .py         (py_reg),
        .pz         (pz_reg),
        .rad        (rad_reg),
        .flags      (flags)
    );

    // A negative range can never cover a corner, so it starts with the fill test failed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_in_reg  <= 1'b0;
            outside_reg <= 1'b0;
            far_reg     <= 1'b0;
            behind_reg  <= 1'b0;
            crossed_reg <= 1'b0;
        end
        else if (accept_classify)
        begin
            all_in_reg  <= !w_c[COORD_BITS-1];
            outside_reg <= 1'b0;
            far_reg     <= 1'b0;
            behind_reg  <= 1'b0;
            crossed_reg <= 1'b0;
        end
        else if (flags.valid)
        begin
            case (flags.kind)
                STEP_CORNER:
                begin
                    if (flags.out_range)
                    begin
                        all_in_reg <= 1'b0;
                    end
                end
                STEP_PLANE:
                begin
                    if (flags.outside)
                    begin
                        outside_reg <= 1'b1;
                    end
                    if (flags.in_band)
                    begin
                        crossed_reg <= 1'b1;
                    end
                    if ((flags.idx == PLANE_NEAR) && flags.below)
                    begin
                        behind_reg <= 1'b1;
                    end
                    if ((flags.idx == PLANE_FAR) && flags.in_band)
                    begin
                        far_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Any plane that puts the sphere fully outside overrides the later priorities.
    always_comb
    begin
        if (all_in_reg)
        begin
            class_next = CLS_FILL;
        end
        else if (outside_reg)
        begin
            class_next = CLS_OUTSIDE;
        end
        else if (far_reg)
        begin
            class_next = CLS_FAR;
        end
        else if (behind_reg)
        begin
            class_next = CLS_BEHIND;
        end
        else if (crossed_reg)
        begin
            class_next = CLS_INSIDE;
        end
        else
        begin
            class_next = CLS_OUTSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            class_reg      <= class_next;
            depth_less_reg <= (class_next == CLS_FAR);
            if (class_next == CLS_INSIDE)
            begin
                cull_reg <= CULL_FRONT;
            end
            else if (class_next == CLS_FAR)
            begin
                cull_reg <= CULL_BACK;
            end
            else
            begin
                cull_reg <= CULL_NONE;
            end
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.position_class  = class_reg;
    assign rsp.depth_test_less = depth_less_reg;
    assign rsp.cull_mode       = cull_reg;

    `SFC_ASSERT_NEXT(a_classify_starts_walk, accept_classify, state_reg == ST_RUN)
    `SFC_ASSERT_NOW(a_last_step_while_draining, flags.valid && flags.last, state_reg == ST_DRAIN)
    `SFC_ASSERT_NOW(a_no_flags_when_idle, state_reg == ST_IDLE, !flags.valid && !mem_tag.valid)
    `SFC_ASSERT_NEXT(a_done_loads_response, (state_reg == ST_DONE) && rsp_free, rsp.valid && (state_reg == ST_IDLE))

endmodule
`default_nettype wire
